@@ hdl/atmp_pkg.sv @@
package atmp_pkg;

   localparam int LINE_BYTES_DEF = 64;
   localparam int ID_BYTES_DEF   = 32;

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_BYTE   = 2'd1;
   localparam logic [1:0] KIND_BUTTON = 2'd2;

   localparam logic [1:0] OUT_TX  = 2'd0;
   localparam logic [1:0] OUT_VER = 2'd1;
   localparam logic [1:0] OUT_ID  = 2'd2;
   localparam logic [1:0] OUT_EVT = 2'd3;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ATTEMPT   = 3'd1;
   localparam logic [2:0] EV_CONNECTED = 3'd2;
   localparam logic [2:0] EV_NO_MODULE = 3'd3;
   localparam logic [2:0] EV_STOPPED   = 3'd4;

   localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
   localparam logic [1:0] REG_TIMEOUT       = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE      = 2'd2;

   // command selectors for the back part
   localparam logic [1:0] CMD_AT  = 2'd0;
   localparam logic [1:0] CMD_VER = 2'd1;
   localparam logic [1:0] CMD_ID  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic       button_level;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [2:0] event_code;
      logic [3:0] attempt_number;
      logic       last;
   } rsp_type;

   // command characters including cr lf
   function automatic logic [7:0] cmd_char(input logic [1:0] cmd, input logic [3:0] idx);
      logic [7:0] c;
      c = 8'd0;
      unique case (cmd)
         CMD_AT: begin
            case (idx)
               4'd0: c = "A";
               4'd1: c = "T";
               4'd2: c = 8'd13;
               default: c = 8'd10;
            endcase
         end
         CMD_VER: begin
            case (idx)
               4'd0: c = "A";
               4'd1: c = "T";
               4'd2: c = "+";
               4'd3: c = "V";
               4'd4: c = "E";
               4'd5: c = "R";
               4'd6: c = 8'd13;
               default: c = 8'd10;
            endcase
         end
         default: begin
            case (idx)
               4'd0: c = "A";
               4'd1: c = "T";
               4'd2: c = "+";
               4'd3: c = "I";
               4'd4: c = "D";
               4'd5: c = "=";
               4'd6: c = "D";
               4'd7: c = "e";
               4'd8: c = "v";
               4'd9: c = "E";
               4'd10: c = "u";
               4'd11: c = "i";
               4'd12: c = 8'd13;
               default: c = 8'd10;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic logic [3:0] cmd_len(input logic [1:0] cmd);
      logic [3:0] n;
      unique case (cmd)
         CMD_AT:  n = 4'd4;
         CMD_VER: n = 4'd8;
         default: n = 4'd14;
      endcase
      return n;
   endfunction

   // job handed from front to back
   typedef enum logic [2:0] {
      JOB_NONE = 3'd0,
      JOB_CMD  = 3'd1,
      JOB_EVT  = 3'd2,
      JOB_VER  = 3'd3,
      JOB_ID   = 3'd4
   } job_kind_type;

endpackage

@@ hdl/atmp_ram.sv @@
module atmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hdl/atmp_outq.sv @@
module atmp_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  atmp_pkg::rsp_type push_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output atmp_pkg::rsp_type pop_data
);
   import atmp_pkg::*;

   rsp_type    buf_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign pop_data = buf_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wp_in  = do_push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, do_push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         buf_ff[wp_ff] <= push_data;
      end
   end
endmodule

@@ hdl/atmp_front.sv @@
module atmp_front #(
   parameter int LINE_BYTES = atmp_pkg::LINE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  atmp_pkg::req_type             in_data,
   output logic                          in_ready,
   input  logic [3:0]                    attempt_limit,
   input  logic [15:0]                   byte_timeout_ticks,
   input  logic [3:0]                    debounce_limit,
   output logic                          line_wr,
   output logic [$clog2(LINE_BYTES)-1:0] line_addr,
   output logic [7:0]                    line_data,
   output logic                          job_valid,
   output atmp_pkg::job_kind_type        job_kind,
   output logic [1:0]                    job_cmd,
   output logic [2:0]                    job_event,
   output logic [3:0]                    job_attempt,
   output logic [$clog2(LINE_BYTES):0]   job_len,
   output logic                          job_last,
   input  logic                          job_ready
);
   import atmp_pkg::*;

   localparam int AW = $clog2(LINE_BYTES);

   typedef enum logic [4:0] {
      PH_WAIT_PRESS   = 5'b00001,
      PH_WAIT_RELEASE = 5'b00010,
      PH_AT           = 5'b00100,
      PH_VER          = 5'b01000,
      PH_ID           = 5'b10000
   } phase_type;

   // up to three jobs per input: pending cmd, and two from the line end
   typedef struct packed {
      job_kind_type kind;
      logic [1:0]   cmd;
      logic [2:0]   ev;
      logic [3:0]   att;
   } job_type;

   phase_type     phase_ff, phase_in;
   logic          stable_ff, stable_in;
   logic [3:0]    differ_ff, differ_in;
   logic [3:0]    att_ff, att_in;
   logic [15:0]   idle_ff, idle_in;
   logic [AW:0]   len_ff, len_in;
   logic [55:0]   win_ff, win_in;
   logic          seen_ff, seen_in;
   logic          pend_ff, pend_in;
   job_type       jobs_ff [3], jobs_in [3];
   logic [1:0]    njob_ff, njob_in, jidx_ff, jidx_in;
   logic [AW:0]   jlen_ff, jlen_in;

   logic          busy, accept;
   phase_type     ph;
   logic [55:0]   w;
   logic          sn, fin, wait_rsp;
   logic [AW:0]   ln;
   logic [1:0]    n;
   logic [3:0]    at;
   logic [4:0]    dn;

   assign busy     = (njob_ff != 2'd0);
   assign in_ready = !busy;
   assign accept   = in_valid && !busy;

   assign job_valid   = busy;
   assign job_kind    = jobs_ff[jidx_ff].kind;
   assign job_cmd     = jobs_ff[jidx_ff].cmd;
   assign job_event   = jobs_ff[jidx_ff].ev;
   assign job_attempt = jobs_ff[jidx_ff].att;
   assign job_len     = jlen_ff;
   assign job_last    = (jidx_ff + 2'd1 == njob_ff);

   always_comb begin
      phase_in  = phase_ff;
      stable_in = stable_ff;
      differ_in = differ_ff;
      att_in    = att_ff;
      idle_in   = idle_ff;
      len_in    = len_ff;
      win_in    = win_ff;
      seen_in   = seen_ff;
      pend_in   = pend_ff;
      njob_in   = njob_ff;
      jidx_in   = jidx_ff;
      jlen_in   = jlen_ff;
      for (int i = 0; i < 3; i++) jobs_in[i] = jobs_ff[i];
      line_wr   = 1'b0;
      line_addr = len_ff[AW-1:0];
      line_data = in_data.rx_byte;
      ph = phase_ff; w = win_ff; sn = seen_ff; ln = len_ff;
      n = 2'd0; fin = 1'b0; at = att_ff; dn = 5'd0; wait_rsp = 1'b0;
      idle_in = idle_ff;

      if (busy) begin
         if (job_ready) begin
            if (job_last) begin
               njob_in = 2'd0;
               jidx_in = 2'd0;
            end else begin
               jidx_in = jidx_ff + 2'd1;
            end
         end
      end else if (accept) begin
         if (pend_ff) begin
            pend_in = 1'b0;
            if (ph == PH_ID) begin
               jobs_in[0] = '{JOB_CMD, CMD_ID, EV_NONE, 4'd0};
               n = 2'd1;
               ln = '0; w = '0; sn = 1'b0; idle_in = '0;
            end
         end
         wait_rsp = (ph == PH_AT) || (ph == PH_VER) || (ph == PH_ID);
         if (in_data.kind == KIND_BUTTON && ph == PH_WAIT_PRESS) begin
            if (in_data.button_level == stable_ff) begin
               differ_in = '0;
            end else begin
               dn = {1'b0, differ_ff} + 5'd1;
               if (dn > {1'b0, debounce_limit}) begin
                  stable_in = in_data.button_level;
                  differ_in = '0;
                  if (!in_data.button_level) ph = PH_WAIT_RELEASE;
               end else begin
                  differ_in = dn[3:0];
               end
            end
         end else if (in_data.kind == KIND_BUTTON && ph == PH_WAIT_RELEASE) begin
            if (in_data.button_level) begin
               at = 4'd0;
               if (attempt_limit == 4'd0) begin
                  jobs_in[n] = '{JOB_EVT, CMD_AT, EV_NO_MODULE, 4'd0};
                  n = n + 2'd1;
                  ph = PH_WAIT_PRESS; stable_in = 1'b1; differ_in = '0;
               end else begin
                  at = 4'd1;
                  jobs_in[n] = '{JOB_EVT, CMD_AT, EV_ATTEMPT, 4'd1};
                  jobs_in[n+2'd1] = '{JOB_CMD, CMD_AT, EV_NONE, 4'd0};
                  n = n + 2'd2;
                  ph = PH_AT; ln = '0; w = '0; sn = 1'b0; idle_in = '0;
               end
            end
         end else if (in_data.kind == KIND_BYTE && wait_rsp) begin
            idle_in = '0;
            if (in_data.rx_byte == 8'd13) begin
               fin = 1'b1;
            end else begin
               w = {w[47:0], in_data.rx_byte};
               unique case (ph)
                  PH_AT:   if (w == "+AT: OK") sn = 1'b1;
                  PH_VER:  if (w[39:0] == "+VER:") sn = 1'b1;
                  default: if (w[47:0] == "DevEui") sn = 1'b1;
               endcase
               line_wr   = 1'b1;
               line_addr = ln[AW-1:0];
               ln = ln + 1'b1;
               if (ln >= (AW+1)'(LINE_BYTES - 1)) fin = 1'b1;
            end
         end else if (in_data.kind == KIND_TICK && wait_rsp) begin
            if (idle_in != 16'hFFFF) idle_in = idle_in + 16'd1;
            if (idle_in >= byte_timeout_ticks) fin = 1'b1;
         end

         if (fin) begin
            unique case (ph)
               PH_AT: begin
                  if (sn) begin
                     jobs_in[n] = '{JOB_EVT, CMD_AT, EV_CONNECTED, 4'd0};
                     jobs_in[n+2'd1] = '{JOB_CMD, CMD_VER, EV_NONE, 4'd0};
                     n = n + 2'd2;
                     ph = PH_VER; ln = '0; w = '0; sn = 1'b0; idle_in = '0;
                  end else if (at >= attempt_limit) begin
                     jobs_in[n] = '{JOB_EVT, CMD_AT, EV_NO_MODULE, 4'd0};
                     n = n + 2'd1;
                     at = 4'd0;
                     ph = PH_WAIT_PRESS; stable_in = 1'b1; differ_in = '0;
                  end else begin
                     at = at + 4'd1;
                     jobs_in[n] = '{JOB_EVT, CMD_AT, EV_ATTEMPT, at};
                     jobs_in[n+2'd1] = '{JOB_CMD, CMD_AT, EV_NONE, 4'd0};
                     n = n + 2'd2;
                     ln = '0; w = '0; sn = 1'b0; idle_in = '0;
                  end
               end
               PH_VER: begin
                  if (sn) begin
                     if (ln != '0) begin
                        jobs_in[n] = '{JOB_VER, CMD_AT, EV_NONE, 4'd0};
                        n = n + 2'd1;
                     end
                     ph = PH_ID;
                     pend_in = 1'b1;
                  end else begin
                     jobs_in[n] = '{JOB_EVT, CMD_AT, EV_STOPPED, 4'd0};
                     n = n + 2'd1;
                     ph = PH_WAIT_PRESS; stable_in = 1'b1; differ_in = '0;
                  end
               end
               default: begin
                  if (sn) begin
                     jobs_in[n] = '{JOB_ID, CMD_AT, EV_NONE, 4'd0};
                     n = n + 2'd1;
                  end else begin
                     jobs_in[n] = '{JOB_EVT, CMD_AT, EV_STOPPED, 4'd0};
                     n = n + 2'd1;
                  end
                  ph = PH_WAIT_PRESS; stable_in = 1'b1; differ_in = '0;
               end
            endcase
         end
         phase_in = ph; win_in = w; seen_in = sn; len_in = ln; att_in = at;
         jlen_in = ln;
         njob_in = n;
         jidx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_PRESS;
         stable_ff <= 1'b1;
         differ_ff <= '0;
         att_ff    <= '0;
         idle_ff   <= '0;
         len_ff    <= '0;
         win_ff    <= '0;
         seen_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         njob_ff   <= '0;
         jidx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         stable_ff <= stable_in;
         differ_ff <= differ_in;
         att_ff    <= att_in;
         idle_ff   <= idle_in;
         len_ff    <= len_in;
         win_ff    <= win_in;
         seen_ff   <= seen_in;
         pend_ff   <= pend_in;
         njob_ff   <= njob_in;
         jidx_ff   <= jidx_in;
      end
      jlen_ff <= jlen_in;
      for (int i = 0; i < 3; i++) jobs_ff[i] <= jobs_in[i];
   end
endmodule

@@ hdl/atmp_back.sv @@
module atmp_back #(
   parameter int LINE_BYTES = atmp_pkg::LINE_BYTES_DEF,
   parameter int ID_BYTES   = atmp_pkg::ID_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  atmp_pkg::job_kind_type        job_kind,
   input  logic [1:0]                    job_cmd,
   input  logic [2:0]                    job_event,
   input  logic [3:0]                    job_attempt,
   input  logic [$clog2(LINE_BYTES):0]   job_len,
   input  logic                          job_last,
   output logic                          job_ready,
   output logic [$clog2(LINE_BYTES)-1:0] rd_addr,
   input  logic [7:0]                    rd_data,
   output logic                          out_push,
   output atmp_pkg::rsp_type             out_data,
   input  logic                          out_full
);
   import atmp_pkg::*;

   localparam int AW = $clog2(LINE_BYTES);
   localparam int IW = $clog2(ID_BYTES);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_CMD  = 6'b000010,
      ST_VER  = 6'b000100,
      ST_SCAN = 6'b001000,
      ST_COPY = 6'b010000,
      ST_EMIT = 6'b100000
   } st_type;

   st_type        st_ff, st_in;
   logic [AW:0]   idx_ff, idx_in;
   logic [AW:0]   start_ff, start_in;
   logic          found_ff, found_in;
   logic          rdv_ff, rdv_in;
   logic [AW:0]   ridx_ff, ridx_in;
   logic [IW:0]   idn_ff, idn_in;
   logic [IW:0]   ide_ff, ide_in;
   logic          id_wr;
   logic [7:0]    id_wdata, id_rdata, lc;
   logic [IW-1:0] id_raddr;

   atmp_ram #(.WIDTH(8), .DEPTH(ID_BYTES)) u_id_ram (
      .clock  (clock),
      .wr_en  (id_wr),
      .wr_addr(idn_ff[IW-1:0]),
      .wr_data(id_wdata),
      .rd_addr(id_raddr),
      .rd_data(id_rdata)
   );

   always_comb begin
      st_in    = st_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      found_in = found_ff;
      rdv_in   = 1'b0;
      ridx_in  = ridx_ff;
      idn_in   = idn_ff;
      ide_in   = ide_ff;
      job_ready = 1'b0;
      out_push  = 1'b0;
      out_data  = '0;
      rd_addr   = idx_ff[AW-1:0];
      id_wr     = 1'b0;
      lc        = rd_data;
      if (rd_data >= "A" && rd_data <= "F") lc = rd_data + 8'd32;
      id_wdata  = lc;
      id_raddr  = ide_ff[IW-1:0];

      unique case (st_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (job_valid) begin
               unique case (job_kind)
                  JOB_EVT: begin
                     out_data = '{OUT_EVT, 8'd0, job_event,
                                  (job_event == EV_ATTEMPT) ? job_attempt : 4'd0, job_last};
                     if (!out_full) begin
                        out_push  = 1'b1;
                        job_ready = 1'b1;
                     end
                  end
                  JOB_CMD: st_in = ST_CMD;
                  JOB_VER: st_in = ST_VER;
                  JOB_ID: begin
                     st_in = ST_SCAN;
                     found_in = 1'b0;
                  end
                  default: job_ready = 1'b1;
               endcase
            end
         end
         ST_CMD: begin
            out_data = '{OUT_TX, cmd_char(job_cmd, idx_ff[3:0]), EV_NONE, 4'd0,
                         job_last && (idx_ff[3:0] == cmd_len(job_cmd) - 4'd1)};
            if (!out_full) begin
               out_push = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff[3:0] == cmd_len(job_cmd) - 4'd1) begin
                  job_ready = 1'b1;
                  st_in = ST_IDLE;
               end
            end
         end
         ST_VER: begin
            // line RAM read is registered; rdv marks data for ridx
            if (rdv_ff) begin
               out_data = '{OUT_VER, rd_data, EV_NONE, 4'd0,
                            job_last && (ridx_ff + 1'b1 == job_len)};
               if (!out_full) begin
                  out_push = 1'b1;
                  if (ridx_ff + 1'b1 == job_len) begin
                     job_ready = 1'b1;
                     st_in = ST_IDLE;
                  end else begin
                     idx_in  = ridx_ff + 1'b1;
                     rd_addr = idx_in[AW-1:0];
                     ridx_in = idx_in;
                     rdv_in  = 1'b1;
                  end
               end else begin
                  rd_addr = ridx_ff[AW-1:0];
                  rdv_in  = 1'b1;
               end
            end else begin
               rd_addr = idx_ff[AW-1:0];
               ridx_in = idx_ff;
               rdv_in  = 1'b1;
            end
         end
         ST_SCAN: begin
            if (rdv_ff) begin
               if (rd_data == " ") begin
                  start_in = ridx_ff + 1'b1;
                  found_in = 1'b1;
               end
            end
            if (idx_ff < job_len) begin
               rd_addr = idx_ff[AW-1:0];
               ridx_in = idx_ff;
               rdv_in  = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!rdv_ff) begin
               idn_in = '0;
               if (!found_ff) begin
                  out_data = '{OUT_EVT, 8'd0, EV_NONE, 4'd0, 1'b0};
                  st_in = ST_EMIT;
                  ide_in = '0;
                  idn_in = '0;
               end else begin
                  idx_in = start_ff;
                  st_in  = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (rdv_ff) begin
               if (rd_data != ":" && idn_ff < (IW+1)'(ID_BYTES - 1)) begin
                  id_wr  = 1'b1;
                  idn_in = idn_ff + 1'b1;
               end
            end
            if (idx_ff < job_len && idn_in < (IW+1)'(ID_BYTES - 1)) begin
               rd_addr = idx_ff[AW-1:0];
               ridx_in = idx_ff;
               rdv_in  = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else if (!rdv_ff || !(rd_data != ":" && idn_ff < (IW+1)'(ID_BYTES - 1))
                         || 1'b1) begin
               if (!rdv_in) begin
                  st_in  = ST_EMIT;
                  ide_in = '0;
                  id_raddr = '0;
               end
            end
         end
         default: begin
            // ide_ff addresses the byte read from the id RAM; rdv marks its data valid
            if (idn_ff == '0) begin
               job_ready = 1'b1;
               st_in = ST_IDLE;
            end else if (!rdv_ff) begin
               id_raddr = ide_ff[IW-1:0];
               rdv_in = 1'b1;
            end else begin
               out_data = '{OUT_ID, id_rdata, EV_NONE, 4'd0,
                            job_last && (ide_ff + 1'b1 == idn_ff)};
               if (!out_full) begin
                  out_push = 1'b1;
                  if (ide_ff + 1'b1 == idn_ff) begin
                     job_ready = 1'b1;
                     st_in = ST_IDLE;
                  end else begin
                     ide_in = ide_ff + 1'b1;
                     id_raddr = ide_in[IW-1:0];
                     rdv_in = 1'b1;
                  end
               end else begin
                  id_raddr = ide_ff[IW-1:0];
                  rdv_in = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         rdv_ff   <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         rdv_ff   <= rdv_in;
         found_ff <= found_in;
      end
      idx_ff   <= idx_in;
      start_ff <= start_in;
      ridx_ff  <= ridx_in;
      idn_ff   <= idn_in;
      ide_ff   <= ide_in;
   end
endmodule

@@ hdl/at_command_modem_probe.sv @@
// an event result goes from the front job registers via the back part into the queue;
// other jobs first pass the back idle state; while the queue is not full, command bytes
// and version text (after a RAM read) come one per cycle, devEui after a line scan
// throughput: one input per cycle when it causes no result; an input with
// results holds off the next until the back part has queued all of them
// reset: synchronous, active high; clears phase, counters, queue; loads setting defaults
module at_command_modem_probe #(
   parameter int LINE_BYTES = atmp_pkg::LINE_BYTES_DEF,
   parameter int ID_BYTES   = atmp_pkg::ID_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  atmp_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output atmp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import atmp_pkg::*;

   localparam int AW = $clog2(LINE_BYTES);

   logic [3:0]  lim_ff;
   logic [15:0] tmo_ff;
   logic [3:0]  deb_ff;
   logic        front_ready, line_wr, job_valid, job_ready, job_last, push, full;
   logic [AW-1:0] line_waddr, line_raddr;
   logic [7:0]  line_wdata, line_rdata;
   job_kind_type job_kind;
   logic [1:0]  job_cmd;
   logic [2:0]  job_event;
   logic [3:0]  job_attempt;
   logic [AW:0] job_len;
   rsp_type     push_data;

   assign csr_ready = 1'b1;
   assign req_full  = !front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= 4'd5;
         tmo_ff <= 16'd500;
         deb_ff <= 4'd3;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ATTEMPT_LIMIT: lim_ff <= csr_data[3:0];
            REG_TIMEOUT:       tmo_ff <= csr_data;
            REG_DEBOUNCE:      deb_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   atmp_front #(.LINE_BYTES(LINE_BYTES)) u_front (
      .clock, .reset,
      .in_valid(req_push), .in_data(req_data), .in_ready(front_ready),
      .attempt_limit(lim_ff), .byte_timeout_ticks(tmo_ff), .debounce_limit(deb_ff),
      .line_wr, .line_addr(line_waddr), .line_data(line_wdata),
      .job_valid, .job_kind, .job_cmd, .job_event, .job_attempt, .job_len,
      .job_last, .job_ready
   );

   atmp_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line_ram (
      .clock, .wr_en(line_wr), .wr_addr(line_waddr), .wr_data(line_wdata),
      .rd_addr(line_raddr), .rd_data(line_rdata)
   );

   atmp_back #(.LINE_BYTES(LINE_BYTES), .ID_BYTES(ID_BYTES)) u_back (
      .clock, .reset,
      .job_valid, .job_kind, .job_cmd, .job_event, .job_attempt, .job_len,
      .job_last, .job_ready,
      .rd_addr(line_raddr), .rd_data(line_rdata),
      .out_push(push), .out_data(push_data), .out_full(full)
   );

   atmp_outq u_outq (
      .clock, .reset, .push, .push_data, .full, .empty(rsp_empty),
      .pop(rsp_pop), .pop_data(rsp_data)
   );
endmodule

@@ hdl/atmp_checker.sv @@
module atmp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input atmp_pkg::rsp_type rsp_data
);
   import atmp_pkg::*;

   ev_zero_byte: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.out_kind == OUT_EVT |-> rsp_data.out_byte == 8'd0)
      else $error("event carries a byte");

   byte_no_event: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.out_kind != OUT_EVT |-> rsp_data.event_code == EV_NONE)
      else $error("byte carries an event code");

   held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

   empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> rsp_empty && !req_full)
      else $error("result present or input blocked after reset");
endmodule

bind at_command_modem_probe atmp_checker u_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_data
);

@@ bench/at_command_modem_probe_test.sv @@
`timescale 1ns / 100ps

module at_command_modem_probe_test;
   import atmp_pkg::*;

   localparam int LINE_MAX = 64;
   localparam int ID_MAX   = 32;

   typedef enum logic [2:0] {
      ST_WAIT_PRESS   = 3'd0,
      ST_WAIT_RELEASE = 3'd1,
      ST_AT           = 3'd2,
      ST_VER          = 3'd3,
      ST_ID           = 3'd4
   } probe_state_type;

   typedef struct {
      req_type item;
      logic    typed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   at_command_modem_probe dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [3:0]  lim_attempts;
   logic [15:0] lim_timeout;
   logic [3:0]  lim_debounce;
   probe_state_type st;
   logic        stable_lvl;
   logic [3:0]  differ_n;
   logic [3:0]  attempt_n;
   logic [15:0] idle_n;
   logic [7:0]  line_buf [LINE_MAX];
   int          line_len;
   logic [55:0] window;
   logic        seen;
   logic        id_cmd_due;

   rsp_type expected_rsps[$];
   int      step_first;
   int      errors = 0;
   int      send_idle = 0;
   int      recv_idle = 0;

   task automatic push_rsp(input logic [1:0] k, input logic [7:0] b,
                           input logic [2:0] ev, input logic [3:0] at);
      rsp_type r;
      r.out_kind = k;
      r.out_byte = b;
      r.event_code = ev;
      r.attempt_number = at;
      r.last = 1'b0;
      expected_rsps.push_back(r);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_rsp(OUT_TX, s[i], EV_NONE, 4'd0);
      push_rsp(OUT_TX, 8'd13, EV_NONE, 4'd0);
      push_rsp(OUT_TX, 8'd10, EV_NONE, 4'd0);
      line_len = 0;
      window = '0;
      seen = 1'b0;
      idle_n = '0;
   endtask

   task automatic go_idle();
      st = ST_WAIT_PRESS;
      stable_lvl = 1'b1;
      differ_n = '0;
   endtask

   task automatic next_attempt();
      if (attempt_n >= lim_attempts) begin
         push_rsp(OUT_EVT, 8'd0, EV_NO_MODULE, 4'd0);
         attempt_n = '0;
         go_idle();
      end else begin
         attempt_n = attempt_n + 4'd1;
         push_rsp(OUT_EVT, 8'd0, EV_ATTEMPT, attempt_n);
         st = ST_AT;
         send_text("AT");
      end
   endtask

   task automatic close_line();
      int  start;
      bit  found;
      int  n;
      logic [7:0] c;
      start = 0;
      found = 0;
      n = 0;
      if (st == ST_AT) begin
         if (seen) begin
            push_rsp(OUT_EVT, 8'd0, EV_CONNECTED, 4'd0);
            st = ST_VER;
            send_text("AT+VER");
         end else next_attempt();
      end else if (st == ST_VER) begin
         if (seen) begin
            for (int i = 0; i < line_len; i++) push_rsp(OUT_VER, line_buf[i], EV_NONE, 4'd0);
            st = ST_ID;
            id_cmd_due = 1'b1;
         end else begin
            push_rsp(OUT_EVT, 8'd0, EV_STOPPED, 4'd0);
            go_idle();
         end
      end else begin
         if (seen) begin
            for (int i = 0; i < line_len; i++)
               if (line_buf[i] == " ") begin
                  start = i + 1;
                  found = 1;
               end
            if (found)
               for (int i = start; i < line_len && n < ID_MAX - 1; i++) begin
                  c = line_buf[i];
                  if (c != ":") begin
                     if (c >= "A" && c <= "F") c = c + 8'd32;
                     push_rsp(OUT_ID, c, EV_NONE, 4'd0);
                     n++;
                  end
               end
         end else push_rsp(OUT_EVT, 8'd0, EV_STOPPED, 4'd0);
         go_idle();
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      string   pat;
      logic [55:0] p;
      logic [55:0] m;
      if (st == ST_AT) pat = "+AT: OK";
      else if (st == ST_VER) pat = "+VER:";
      else pat = "DevEui";
      p = '0;
      for (int i = 0; i < pat.len(); i++) p = {p[47:0], pat[i]};
      m = (56'd1 << (8 * pat.len())) - 56'd1;
      window = {window[47:0], c};
      if ((window & m) == p) seen = 1'b1;
      line_buf[line_len] = c;
      line_len++;
   endtask

   // works out the results of one accepted input beat
   task automatic predict_probe(input req_type it);
      bit waiting;
      step_first = expected_rsps.size();
      if (id_cmd_due) begin
         id_cmd_due = 1'b0;
         if (st == ST_ID) send_text("AT+ID=DevEui");
      end
      waiting = (st == ST_AT || st == ST_VER || st == ST_ID);
      if (it.kind == KIND_BUTTON && st == ST_WAIT_PRESS) begin
         if (it.button_level == stable_lvl) differ_n = '0;
         else if (differ_n + 5'd1 > {1'b0, lim_debounce}) begin
            stable_lvl = it.button_level;
            differ_n = '0;
            if (!it.button_level) st = ST_WAIT_RELEASE;
         end else differ_n = differ_n + 4'd1;
      end else if (it.kind == KIND_BUTTON && st == ST_WAIT_RELEASE) begin
         if (it.button_level) begin
            attempt_n = '0;
            next_attempt();
         end
      end else if (it.kind == KIND_BYTE && waiting) begin
         idle_n = '0;
         if (it.rx_byte == 8'd13) close_line();
         else begin
            take_char(it.rx_byte);
            if (line_len >= LINE_MAX - 1) close_line();
         end
      end else if (it.kind == KIND_TICK && waiting) begin
         if (idle_n != 16'hFFFF) idle_n++;
         if (idle_n >= lim_timeout) close_line();
      end
      if (expected_rsps.size() > step_first)
         expected_rsps[expected_rsps.size() - 1].last = 1'b1;
   endtask

   task automatic predictor_reset();
      lim_attempts = 4'd5;
      lim_timeout = 16'd500;
      lim_debounce = 4'd3;
      go_idle();
      attempt_n = '0;
      idle_n = '0;
      line_len = 0;
      window = '0;
      seen = 1'b0;
      id_cmd_due = 1'b0;
   endtask

   // response side: pop with random stalls, compare each beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: result mismatch expected %p actual %p",
                           $time, expected_rsps[0], rsp_data);
                  errors++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // push stays high after an accepted beat until the next item or an idle cycle
   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_probe(it);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_ATTEMPT_LIMIT) lim_attempts = val[3:0];
      else if (idx == REG_TIMEOUT) lim_timeout = val;
      else lim_debounce = val[3:0];
   endtask

   function automatic req_type mk(input logic [1:0] k, input logic [7:0] b,
                                  input logic l);
      req_type r;
      r.kind = k;
      r.rx_byte = b;
      r.button_level = l;
      return r;
   endfunction

   task automatic send_line(input string s, input bit with_cr);
      for (int i = 0; i < s.len(); i++)
         send_item(mk(KIND_BYTE, s[i], 1'($urandom_range(1))));
      if (with_cr) send_item(mk(KIND_BYTE, 8'd13, 1'($urandom_range(1))));
   endtask

   task automatic press_release();
      repeat (int'(lim_debounce) + 1) send_item(mk(KIND_BUTTON, 8'($urandom), 1'b0));
      send_item(mk(KIND_BUTTON, 8'($urandom), 1'b1));
   endtask

   function automatic string rand_text(input int n);
      string s;
      byte   c;
      s = "";
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(5))
            0: c = " ";
            1: c = ":";
            2: c = 8'($urandom_range(8'h41, 8'h46));
            3: c = 8'($urandom_range(8'h30, 8'h39));
            default: c = 8'($urandom_range(8'h20, 8'h7e));
         endcase
         s = {s, string'(c)};
      end
      return s;
   endfunction

   // one session with random content; ends back in the idle state
   task automatic random_session();
      int roll;
      press_release();
      while (st != ST_WAIT_PRESS) begin
         roll = $urandom_range(99);
         if (st == ST_AT) begin
            if (roll < 55) send_line({rand_text($urandom_range(3)), "+AT: OK"}, 1);
            else if (roll < 85) send_line(rand_text($urandom_range(6)), 1);
            else begin
               send_line(rand_text($urandom_range(2)), 0);
               while (st == ST_AT && line_len != 0 || idle_n != 0 && st == ST_AT)
                  send_item(mk(KIND_TICK, 8'($urandom), 1'($urandom_range(1))));
               if (st == ST_AT) send_item(mk(KIND_BYTE, 8'd13, 1'b0));
            end
         end else if (st == ST_VER) begin
            if (roll < 85) send_line({"+VER:", rand_text($urandom_range(10))}, 1);
            else send_line(rand_text(3), 1);
         end else begin
            if (roll < 15) send_item(mk(KIND_BYTE, 8'($urandom_range(255)), 1'b0));
            else if (roll < 90)
               send_line({"DevEui", rand_text($urandom_range(30))}, 1);
            else send_line("xy", 1);
         end
      end
   endtask

   stim_row_type rows[$];

   task automatic add_row(input req_type it, input bit typed, input rsp_type r);
      stim_row_type s;
      s.item = it;
      s.typed = typed;
      s.rsp = r;
      rows.push_back(s);
   endtask

   initial begin
      rsp_type none;
      rsp_type no_mod;
      int phase_no;
      none = '0;
      no_mod = '{OUT_EVT, 8'd0, EV_NO_MODULE, 4'd0, 1'b1};
      predictor_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ignored inputs after reset, then attempt limit of zero
      add_row(mk(KIND_TICK, 8'hFF, 1'b1), 1, none);
      add_row(mk(KIND_BYTE, 8'h00, 1'b0), 1, none);
      add_row(mk(KIND_BYTE, 8'hFF, 1'b1), 1, none);
      add_row(mk(2'd3, 8'hA5, 1'b0), 1, none);
      add_row(mk(KIND_BUTTON, 8'h00, 1'b0), 1, none);
      add_row(mk(KIND_BUTTON, 8'h00, 1'b0), 1, none);
      add_row(mk(KIND_BUTTON, 8'h00, 1'b0), 1, none);
      add_row(mk(KIND_BUTTON, 8'h00, 1'b0), 0, none);
      add_row(mk(KIND_BUTTON, 8'h00, 1'b1), 0, none);
      write_reg(REG_ATTEMPT_LIMIT, 16'd0);
      write_reg(REG_DEBOUNCE, 16'd0);
      write_reg(REG_TIMEOUT, 16'd0);
      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].typed && (expected_rsps.size() != step_first)) begin
            $display("%0t: row %0d expected %p, model disagrees", $time, i, rows[i].rsp);
            errors++;
         end
      end
      send_item(mk(KIND_BUTTON, 8'h00, 1'b0));
      send_item(mk(KIND_BUTTON, 8'h00, 1'b1));
      if (expected_rsps.size() == 0 || expected_rsps[expected_rsps.size() - 1] !== no_mod) begin
         $display("%0t: expected %p actual queue tail differs", $time, no_mod);
         errors++;
      end
      drain();

      // directed: full session, timeout of zero, zero byte, full line, long id
      write_reg(REG_ATTEMPT_LIMIT, 16'd15);
      press_release();
      send_item(mk(KIND_TICK, 8'h00, 1'b0));
      send_line("+AT: OK", 1);
      send_item(mk(KIND_BYTE, 8'h00, 1'b0));
      send_line("+VER:", 0);
      for (int i = 0; i < 57; i++) send_item(mk(KIND_BYTE, 8'h7E, 1'b1));
      send_line("DevEui AA:BB:CC:DD:EE:FF:00:11:22:33:44:55:66:77:88:99:AB", 1);
      drain();
      press_release();
      send_line("+AT: OK", 1);
      send_line("+VER:1", 1);
      send_line("DevEui", 1);
      drain();
      write_reg(REG_TIMEOUT, 16'hFFFF);
      write_reg(REG_DEBOUNCE, 16'd15);
      press_release();
      for (int i = 0; i < 20; i++) send_item(mk(KIND_TICK, 8'h00, 1'b0));
      send_line("+AT: OK", 1);
      send_line("no", 1);
      drain();

      // random phases with different settings and idling
      for (phase_no = 0; phase_no < 3; phase_no++) begin
         send_idle = (phase_no == 0) ? 38 : (phase_no == 1) ? 49 : 0;
         recv_idle = (phase_no == 0) ? 49 : (phase_no == 1) ? 38 : 0;
         write_reg(REG_ATTEMPT_LIMIT, 16'($urandom_range(1, 15)));
         write_reg(REG_TIMEOUT, 16'($urandom_range(1, 6)));
         write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 4)));
         repeat (1) begin
            random_session();
            // noise between sessions
            repeat ($urandom_range(4))
               send_item(mk(2'($urandom_range(3)), 8'($urandom), 1'($urandom)));
         end
         drain();
      end

      if (errors == 0 && expected_rsps.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ at_command_modem_probe.f @@
hdl/atmp_pkg.sv
hdl/atmp_ram.sv
hdl/atmp_outq.sv
hdl/atmp_front.sv
hdl/atmp_back.sv
hdl/at_command_modem_probe.sv
hdl/atmp_checker.sv
bench/at_command_modem_probe_test.sv
